// ----- rtl/cache_replacement_policy_unit_defines.svh -----
// assertion helpers for the replacement engine
`ifndef CACHE_REPLACEMENT_POLICY_UNIT_DEFINES_SVH
`define CACHE_REPLACEMENT_POLICY_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/crp_pkg.sv -----
package crp_pkg;

  // default build
  localparam int NUM_WAYS_DEF  = 8;
  localparam int NUM_SETS_DEF  = 256;
  localparam int RANK_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'b1;

  // policy codes
  localparam logic [2:0] POL_RANDOM = 3'd0;
  localparam logic [2:0] POL_LRU    = 3'd1;
  localparam logic [2:0] POL_LFU    = 3'd2;
  localparam logic [2:0] POL_FIFO   = 3'd3;
  localparam logic [2:0] POL_LIFO   = 3'd4;

  // item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // access outcomes
  localparam logic [1:0] OUT_HIT       = 2'd0;
  localparam logic [1:0] OUT_REPL_MISS = 2'd1;
  localparam logic [1:0] OUT_COMP_MISS = 2'd2;

  // random source
  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // remainder unit: bits per cycle and cycles per remainder
  localparam int MOD_STEP   = 4;
  localparam int MOD_CYCLES = LFSR_W / MOD_STEP;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RMW   = 4'b0100,
    ST_MOD   = 4'b1000
  } state_e;

  // right-shifting fibonacci lfsr, taps 16 14 13 11
  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

endpackage

// ----- rtl/cache_replacement_policy_unit.sv -----
// an access item reads its set row on accept and writes it back at the end of the rmw state;
// a query result strobes after the rmw state, for a random query on an existing set after the
// remainder unit; a new item is taken only in idle, so the read-modify-write of one set row in
// the single-port row memory keeps busy high in the rmw state, and random queries also hold
// busy while the remainder unit runs; reset: config to defaults, lfsr to its seed, then a
// clearing pass (busy high) zeroes every row; the result receiver cannot stall
`include "cache_replacement_policy_unit_defines.svh"

module cache_replacement_policy_unit #(
  parameter int NUM_WAYS  = crp_pkg::NUM_WAYS_DEF,
  parameter int NUM_SETS  = crp_pkg::NUM_SETS_DEF,
  parameter int RANK_BITS = crp_pkg::RANK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [crp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind_i,
  input  logic [7:0]                     set_index_i,
  input  logic [2:0]                     way_i,
  input  logic [1:0]                     outcome_i,
  // result side
  output logic                           victim_valid_o,
  output logic [2:0]                     victim_way_o
);

  // widths derived from the build
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WIDX  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AW    = $clog2(NUM_WAYS + 1);     // holds the ways in use, 1..NUM_WAYS
  localparam int CW    = RANK_BITS + 1;            // rank compared against a way count
  localparam int RANKS_W = NUM_WAYS * RANK_BITS;
  localparam int ROW_W   = RANKS_W + NUM_WAYS;     // one set: all ranks, then valid bits

  // ---------------------------------------------------------------------------
  // control and configuration
  // ---------------------------------------------------------------------------
  crp_pkg::state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q;
  logic [2:0]       policy_mode_q;
  logic [3:0]       ways_in_use_q;
  logic [crp_pkg::LFSR_W-1:0] lfsr_q;
  logic [crp_pkg::LFSR_W-1:0] lfsr_next;
  logic [crp_pkg::MOD_CNT_W-1:0] mod_cnt_q;
  logic victim_valid_q;
  logic [2:0] victim_way_q;

  // item held for the read-modify-write cycle
  logic             kind_q;
  logic [2:0]       way_q;
  logic [1:0]       outcome_q;
  logic             set_ok_q;
  logic [SET_W-1:0] addr_q;

  // row memory: ranks and valid bits of one set per entry
  logic [ROW_W-1:0] row_mem_q [NUM_SETS];
  logic [ROW_W-1:0] rd_row_q;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  logic accept;
  logic clr_last;
  logic mod_last;
  logic rnd_query;

  assign accept   = start && (state_q == crp_pkg::ST_IDLE);
  assign busy     = (state_q != crp_pkg::ST_IDLE);
  assign clr_last = (clr_cnt_q == SET_W'(NUM_SETS - 1));
  assign mod_last = (mod_cnt_q == crp_pkg::MOD_CNT_W'(crp_pkg::MOD_CYCLES - 1));
  assign lfsr_next = crp_pkg::lfsr_advance(lfsr_q);

  // random query on a set that exists: lfsr steps and the remainder unit runs
  assign rnd_query = (kind_q == crp_pkg::KIND_QUERY) && set_ok_q &&
                     (policy_mode_q == crp_pkg::POL_RANDOM);

  // ---------------------------------------------------------------------------
  // effective ways in use: 0 acts as 1, above the build acts as NUM_WAYS
  // ---------------------------------------------------------------------------
  logic [AW-1:0] a_eff;
  logic [AW-1:0] a_m1;
  logic [RANK_BITS-1:0] a_m1_rank;
  logic [NUM_WAYS-1:0]  in_use;

  always_comb begin
    if (ways_in_use_q == '0) begin
      a_eff = AW'(1);
    end else if (32'(ways_in_use_q) > NUM_WAYS) begin
      a_eff = AW'(NUM_WAYS);
    end else begin
      a_eff = AW'(ways_in_use_q);
    end
  end

  assign a_m1      = a_eff - AW'(1);
  assign a_m1_rank = RANK_BITS'(a_m1);

  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      in_use[j] = (AW'(j) < a_eff);
    end
  end

  // ---------------------------------------------------------------------------
  // row update for an access item
  // ---------------------------------------------------------------------------
  logic [NUM_WAYS-1:0][RANK_BITS-1:0] rank_rd, rank_new;
  logic [NUM_WAYS-1:0]                valid_rd, valid_new;
  logic [WIDX-1:0]      way_idx;
  logic                 way_ok;
  logic                 miss;
  logic [RANK_BITS-1:0] old_rank;
  logic [WIDX-1:0]      fifo_id;
  logic [AW-1:0]        vcnt;

  assign rank_rd  = rd_row_q[RANKS_W-1:0];
  assign valid_rd = rd_row_q[ROW_W-1:RANKS_W];
  assign way_idx  = WIDX'(way_q);
  assign way_ok   = (32'(way_q) < 32'(a_eff));
  assign miss     = outcome_q inside {crp_pkg::OUT_REPL_MISS, crp_pkg::OUT_COMP_MISS};
  assign old_rank = rank_rd[way_idx];

  always_comb begin
    rank_new  = rank_rd;
    valid_new = valid_rd;
    fifo_id   = way_idx;
    vcnt      = '0;
    if (miss) begin
      valid_new[way_idx] = 1'b1;
    end
    case (policy_mode_q)
      crp_pkg::POL_LRU: begin
        // accessed way becomes newest, the ones above its old rank slide down
        if (old_rank != a_m1_rank) begin
          for (int j = 0; j < NUM_WAYS; j++) begin
            if (WIDX'(j) == way_idx) begin
              rank_new[j] = a_m1_rank;
            end else if (in_use[j] && valid_new[j] && (rank_rd[j] > old_rank)) begin
              rank_new[j] = rank_rd[j] - RANK_BITS'(1);
            end
          end
        end
      end
      crp_pkg::POL_LFU: begin
        if (miss) begin
          rank_new[way_idx] = '0;
        end else if (old_rank != '1) begin
          rank_new[way_idx] = old_rank + RANK_BITS'(1);
        end
      end
      crp_pkg::POL_FIFO: begin
        if (outcome_q == crp_pkg::OUT_COMP_MISS) begin
          // fill order: count of valid ways in use, less one
          for (int j = 0; j < NUM_WAYS; j++) begin
            if (in_use[j] && valid_new[j]) begin
              vcnt = vcnt + AW'(1);
            end
          end
          rank_new[way_idx] = RANK_BITS'(vcnt - AW'(1));
        end else if (outcome_q == crp_pkg::OUT_REPL_MISS) begin
          // highest way at rank zero is replaced, accessed way if none
          for (int j = 0; j < NUM_WAYS; j++) begin
            if (in_use[j] && (rank_rd[j] == '0)) begin
              fifo_id = WIDX'(j);
            end
          end
          for (int j = 0; j < NUM_WAYS; j++) begin
            if (in_use[j]) begin
              if (WIDX'(j) == fifo_id) begin
                rank_new[j] = a_m1_rank;
              end else if (rank_rd[j] != '0) begin
                rank_new[j] = rank_rd[j] - RANK_BITS'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // victim for a query item (all policies but random)
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   best;
  logic [WIDX-1:0] best_id;
  logic [2:0]      victim_cmb;

  always_comb begin
    // lfu starts from way 0's rank, so way 0 wins a tie with it
    if (policy_mode_q == crp_pkg::POL_LFU) begin
      best = {1'b0, rank_rd[0]};
    end else begin
      best = CW'(a_eff);
    end
    best_id = '0;
    for (int j = 0; j < NUM_WAYS; j++) begin
      if (in_use[j] && ({1'b0, rank_rd[j]} < best)) begin
        best    = {1'b0, rank_rd[j]};
        best_id = WIDX'(j);
      end
    end
  end

  always_comb begin
    victim_cmb = '0;
    if (set_ok_q) begin
      case (policy_mode_q)
        crp_pkg::POL_LRU,
        crp_pkg::POL_LFU,
        crp_pkg::POL_FIFO: victim_cmb = 3'(best_id);
        crp_pkg::POL_LIFO: victim_cmb = 3'(a_m1);
        default:           victim_cmb = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // remainder unit: lfsr value modulo ways in use, MOD_STEP bits a cycle
  // ---------------------------------------------------------------------------
  logic [crp_pkg::LFSR_W-1:0] mod_dvd_q, mod_dvd_n;
  logic [AW-1:0]              mod_rem_q, mod_rem_n;
  logic [AW:0]                mod_t;

  always_comb begin
    mod_dvd_n = mod_dvd_q;
    mod_rem_n = mod_rem_q;
    mod_t     = '0;
    for (int k = 0; k < crp_pkg::MOD_STEP; k++) begin
      mod_t     = {mod_rem_n, mod_dvd_n[crp_pkg::LFSR_W-1]};
      mod_dvd_n = mod_dvd_n << 1;
      if (mod_t >= {1'b0, a_eff}) begin
        mod_t = mod_t - {1'b0, a_eff};
      end
      mod_rem_n = mod_t[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      crp_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = crp_pkg::ST_IDLE;
        end
      end
      crp_pkg::ST_IDLE: begin
        if (start) begin
          state_d = crp_pkg::ST_RMW;
        end
      end
      crp_pkg::ST_RMW: begin
        state_d = rnd_query ? crp_pkg::ST_MOD : crp_pkg::ST_IDLE;
      end
      crp_pkg::ST_MOD: begin
        if (mod_last) begin
          state_d = crp_pkg::ST_IDLE;
        end
      end
      default: state_d = crp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= crp_pkg::ST_CLEAR;
      clr_cnt_q      <= '0;
      policy_mode_q  <= crp_pkg::POL_RANDOM;
      ways_in_use_q  <= 4'd1;
      lfsr_q         <= crp_pkg::LFSR_SEED;
      mod_cnt_q      <= '0;
      victim_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == crp_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + SET_W'(1);
      end
      // configuration is taken in any state
      if (cfg_we_i) begin
        case (cfg_index_i)
          crp_pkg::CFG_POLICY_MODE: policy_mode_q <= cfg_wdata_i[2:0];
          crp_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata_i[3:0];
          default: begin
          end
        endcase
      end
      if ((state_q == crp_pkg::ST_RMW) && rnd_query) begin
        lfsr_q    <= lfsr_next;
        mod_cnt_q <= '0;
      end else if (state_q == crp_pkg::ST_MOD) begin
        mod_cnt_q <= mod_cnt_q + crp_pkg::MOD_CNT_W'(1);
      end
      victim_valid_q <= ((state_q == crp_pkg::ST_RMW) && (kind_q == crp_pkg::KIND_QUERY) &&
                         !rnd_query) ||
                        ((state_q == crp_pkg::ST_MOD) && mod_last);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_i;
      way_q     <= way_i;
      outcome_q <= outcome_i;
      set_ok_q  <= (32'(set_index_i) < NUM_SETS);
      addr_q    <= SET_W'(set_index_i);
    end
    if ((state_q == crp_pkg::ST_RMW) && rnd_query) begin
      mod_dvd_q <= lfsr_next;
      mod_rem_q <= '0;
    end else if (state_q == crp_pkg::ST_MOD) begin
      mod_dvd_q <= mod_dvd_n;
      mod_rem_q <= mod_rem_n;
    end
    if (state_q == crp_pkg::ST_RMW) begin
      victim_way_q <= victim_cmb;
    end else if (state_q == crp_pkg::ST_MOD) begin
      victim_way_q <= 3'(mod_rem_n);
    end
  end

  // ---------------------------------------------------------------------------
  // row memory: cleared after reset, read on accept, write back at the end of the rmw cycle
  // ---------------------------------------------------------------------------
  assign mem_we = (state_q == crp_pkg::ST_CLEAR) ||
                  ((state_q == crp_pkg::ST_RMW) && (kind_q == crp_pkg::KIND_ACCESS) &&
                   set_ok_q && way_ok);
  assign mem_waddr = (state_q == crp_pkg::ST_CLEAR) ? clr_cnt_q : addr_q;
  assign mem_wdata = (state_q == crp_pkg::ST_CLEAR) ? '0 : {valid_new, rank_new};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= row_mem_q[SET_W'(set_index_i)];
    end
  end

  assign victim_valid_o = victim_valid_q;
  assign victim_way_o   = victim_way_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `CRP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left the block idle")
  `CRP_ASSERT_NEXT(a_strobe_single, victim_valid_o, !victim_valid_o, "result strobe too long")
  `CRP_ASSERT(a_no_result_clear, (state_q == crp_pkg::ST_CLEAR) |-> !victim_valid_o, "result during clear")
  `CRP_ASSERT(a_victim_range, victim_valid_o |-> (32'(victim_way_o) < NUM_WAYS), "victim out of range")
  `CRP_ASSERT(a_idle_no_write, (state_q == crp_pkg::ST_IDLE) |-> !mem_we, "row write while idle")

endmodule

// ----- tb/sv/cache_replacement_policy_unit_tb.sv -----
`timescale 1ns / 100ps

module cache_replacement_policy_unit_tb;

  localparam int NW = crp_pkg::NUM_WAYS_DEF;
  localparam int NS = crp_pkg::NUM_SETS_DEF;
  localparam int RANK_W = crp_pkg::RANK_BITS_DEF;

  // policy codes the block does not implement, and the outcome code with no meaning
  localparam logic [2:0] POL_UNUSED = 3'd5;
  localparam logic [2:0] POL_MAX = 3'd7;
  localparam logic [1:0] OUT_RESERVED = 2'd3;

  localparam int DRAIN_CYCLES = 8;        // an access is written back at the end of the rmw state
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic       kind;
    logic [7:0] set_index;
    logic [2:0] way;
    logic [1:0] outcome;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [crp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [crp_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic kind_i = crp_pkg::KIND_ACCESS;
  logic [7:0] set_index_i = '0;
  logic [2:0] way_i = '0;
  logic [1:0] outcome_i = crp_pkg::OUT_HIT;
  logic victim_valid_o;
  logic [2:0] victim_way_o;

  // shadow copy of the block state
  logic [RANK_W-1:0] rank_mem [NS][NW];
  logic valid_mem [NS][NW];
  logic [crp_pkg::LFSR_W-1:0] shadow_lfsr = crp_pkg::LFSR_SEED;
  logic [2:0] shadow_policy = crp_pkg::POL_RANDOM;
  logic [3:0] shadow_ways = 4'd1;

  cmd_t cmd_backlog [$];
  logic [2:0] expected_victims [$];
  int unsigned idle_pct = 34;
  int unsigned err_cnt = 0;
  int unsigned items_cnt = 0;
  int unsigned victims_cnt = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt = 0;

  cache_replacement_policy_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .set_index_i   (set_index_i),
    .way_i         (way_i),
    .outcome_i     (outcome_i),
    .victim_valid_o(victim_valid_o),
    .victim_way_o  (victim_way_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ways register clamped into 1..NW
  function automatic int unsigned active_ways();
    int unsigned a;
    a = shadow_ways;
    if (a < 1) a = 1;
    if (a > NW) a = NW;
    return a;
  endfunction

  // rank and valid update of one access
  function automatic void update_ranks(logic [7:0] s, logic [2:0] w, logic [1:0] oc);
    int unsigned a, cnt, id;
    logic [RANK_W-1:0] old;
    logic miss;
    a = active_ways();
    miss = (oc == crp_pkg::OUT_REPL_MISS) || (oc == crp_pkg::OUT_COMP_MISS);
    // a way outside the ways in use leaves everything untouched
    if (w >= a) return;
    if (miss) valid_mem[s][w] = 1'b1;
    case (shadow_policy)
      crp_pkg::POL_LRU: begin
        old = rank_mem[s][w];
        // the newest way already holds the top rank
        if (old != RANK_W'(a - 1)) begin
          rank_mem[s][w] = RANK_W'(a - 1);
          for (int j = 0; j < a; j++)
            if (j != w && valid_mem[s][j] && rank_mem[s][j] > old)
              rank_mem[s][j] = rank_mem[s][j] - 1'b1;
        end
      end
      crp_pkg::POL_LFU: begin
        if (miss) rank_mem[s][w] = '0;
        else if (rank_mem[s][w] != {RANK_W{1'b1}}) rank_mem[s][w] = rank_mem[s][w] + 1'b1;
      end
      crp_pkg::POL_FIFO: begin
        if (oc == crp_pkg::OUT_COMP_MISS) begin
          cnt = 0;
          for (int j = 0; j < a; j++)
            if (valid_mem[s][j]) cnt++;
          rank_mem[s][w] = RANK_W'(cnt - 1);
        end else if (oc == crp_pkg::OUT_REPL_MISS) begin
          // highest way of rank zero is the one refilled, else the named way
          id = w;
          for (int j = 0; j < a; j++)
            if (rank_mem[s][j] == '0) id = j;
          rank_mem[s][id] = RANK_W'(a - 1);
          for (int j = 0; j < a; j++)
            if (j != id && rank_mem[s][j] != '0) rank_mem[s][j] = rank_mem[s][j] - 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // victim of one query, stepping the lfsr under random policy
  function automatic logic [2:0] next_victim(logic [7:0] s);
    int unsigned a, best, id;
    logic fb;
    a = active_ways();
    id = 0;
    case (shadow_policy)
      crp_pkg::POL_RANDOM: begin
        fb = shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5];
        shadow_lfsr = {fb, shadow_lfsr[crp_pkg::LFSR_W-1:1]};
        id = shadow_lfsr % a;
      end
      crp_pkg::POL_LRU, crp_pkg::POL_FIFO: begin
        // no rank below the way count gives way 0
        best = a;
        for (int j = 0; j < a; j++)
          if (rank_mem[s][j] < best) begin
            best = rank_mem[s][j];
            id = j;
          end
      end
      crp_pkg::POL_LFU: begin
        // a tie with way 0 keeps way 0
        best = rank_mem[s][0];
        for (int j = 0; j < a; j++)
          if (rank_mem[s][j] < best) begin
            best = rank_mem[s][j];
            id = j;
          end
      end
      crp_pkg::POL_LIFO: id = a - 1;
      default: id = 0;
    endcase
    return id[2:0];
  endfunction

  // command driver: holds start until the block takes the item
  always @(posedge clk_i) begin : drive_items
    cmd_t nxt;
    logic [2:0] pick;
    if (rst_ni) begin
      if (start && !busy) begin
        items_cnt++;
        if (kind_i == crp_pkg::KIND_QUERY) begin
          pick = next_victim(set_index_i);
          expected_victims.push_back(pick);
        end else begin
          update_ranks(set_index_i, way_i, outcome_i);
        end
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          nxt = cmd_backlog.pop_front();
          start <= 1'b1;
          kind_i <= nxt.kind;
          set_index_i <= nxt.set_index;
          way_i <= nxt.way;
          outcome_i <= nxt.outcome;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe must match the oldest expected victim
  always @(posedge clk_i) begin : check_victims
    logic [2:0] want;
    if (rst_ni && victim_valid_o) begin
      victims_cnt++;
      if (expected_victims.size() == 0) begin
        $error("victim_way: unexpected result %0d", victim_way_o);
        err_cnt++;
      end else begin
        want = expected_victims.pop_front();
        if (victim_way_o !== want) begin
          $error("victim_way: expected %0d, got %0d", want, victim_way_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cache_replacement_policy_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic push_item(input logic k, input logic [7:0] s, input logic [2:0] w,
                           input logic [1:0] oc);
    cmd_t c;
    c.kind = k;
    c.set_index = s;
    c.way = w;
    c.outcome = oc;
    cmd_backlog.push_back(c);
  endtask

  // wait until every item is taken, every victim seen and the last access retired
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || busy || expected_victims.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // both registers written back to back on an idle block
  task automatic set_policy(input logic [2:0] pol, input logic [3:0] ways);
    settle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= crp_pkg::CFG_POLICY_MODE;
    cfg_wdata_i <= crp_pkg::CFG_DATA_W'(pol);
    @(posedge clk_i);
    cfg_index_i <= crp_pkg::CFG_WAYS_IN_USE;
    cfg_wdata_i <= ways;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_policy = pol;
    shadow_ways = ways;
    settings_cnt++;
  endtask

  // in most phases fill three sets, then hammer them with hits, misses and queries
  task automatic random_phase(input int unsigned n);
    logic [7:0] pool [3];
    int unsigned a, done_cnt, r;
    cmd_t c;
    a = active_ways();
    done_cnt = 0;
    foreach (pool[i]) pool[i] = 8'($urandom_range(255, 0));
    // most phases start with a compulsory fill of each set
    if ($urandom_range(3, 0) != 0) begin
      foreach (pool[i])
        for (int w = 0; w < a; w++) begin
          push_item(crp_pkg::KIND_ACCESS, pool[i], 3'(w), crp_pkg::OUT_COMP_MISS);
          done_cnt++;
        end
    end
    while (done_cnt < n) begin
      c.set_index = ($urandom_range(9, 0) == 0) ? 8'($urandom) : pool[$urandom_range(2, 0)];
      if ($urandom_range(99, 0) < 30) begin
        c.kind = crp_pkg::KIND_QUERY;
        c.way = 3'($urandom);
        c.outcome = 2'($urandom);
      end else begin
        c.kind = crp_pkg::KIND_ACCESS;
        // now and then a way outside the ways in use
        c.way = ($urandom_range(9, 0) == 0) ? 3'($urandom) : 3'($urandom_range(a - 1, 0));
        r = $urandom_range(19, 0);
        c.outcome = (r < 10) ? crp_pkg::OUT_HIT : (r < 15) ? crp_pkg::OUT_REPL_MISS :
                    (r < 18) ? crp_pkg::OUT_COMP_MISS : OUT_RESERVED;
      end
      cmd_backlog.push_back(c);
      if (c.kind == crp_pkg::KIND_QUERY || c.way < a) done_cnt++;
    end
  endtask

  initial begin : stimulus
    logic [2:0] pol;
    logic [3:0] ways;
    foreach (rank_mem[i, j]) begin
      rank_mem[i][j] = '0;
      valid_mem[i][j] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its row memory after reset with busy high
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // reset defaults: random policy over one way
    push_item(crp_pkg::KIND_QUERY, 8'd0, 3'd0, crp_pkg::OUT_HIT);

    // lru: fill, hit in the middle, hit on the newest way, extreme sets
    set_policy(crp_pkg::POL_LRU, 4'd8);
    for (int w = 0; w < 4; w++) begin
      push_item(crp_pkg::KIND_ACCESS, 8'd0, 3'(w), crp_pkg::OUT_COMP_MISS);
    end
    push_item(crp_pkg::KIND_ACCESS, 8'd0, 3'd1, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_ACCESS, 8'd0, 3'd1, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_QUERY, 8'd0, 3'd0, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_QUERY, 8'd255, 3'd7, OUT_RESERVED);

    // lfu: reserved outcome counts as a hit, a miss clears the count
    set_policy(crp_pkg::POL_LFU, 4'd8);
    push_item(crp_pkg::KIND_ACCESS, 8'd255, 3'd7, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_ACCESS, 8'd255, 3'd7, OUT_RESERVED);
    push_item(crp_pkg::KIND_ACCESS, 8'd255, 3'd0, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_ACCESS, 8'd255, 3'd0, crp_pkg::OUT_REPL_MISS);
    push_item(crp_pkg::KIND_QUERY, 8'd255, 3'd0, crp_pkg::OUT_HIT);

    // fifo: fills, a replacement, a hit, and a way beyond the ways in use
    set_policy(crp_pkg::POL_FIFO, 4'd4);
    push_item(crp_pkg::KIND_ACCESS, 8'd1, 3'd0, crp_pkg::OUT_COMP_MISS);
    push_item(crp_pkg::KIND_ACCESS, 8'd1, 3'd1, crp_pkg::OUT_COMP_MISS);
    push_item(crp_pkg::KIND_ACCESS, 8'd1, 3'd2, crp_pkg::OUT_REPL_MISS);
    push_item(crp_pkg::KIND_ACCESS, 8'd1, 3'd0, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_ACCESS, 8'd1, 3'd5, crp_pkg::OUT_COMP_MISS);
    push_item(crp_pkg::KIND_QUERY, 8'd1, 3'd0, crp_pkg::OUT_HIT);

    // lifo with ways above the build, clamped to all ways
    set_policy(crp_pkg::POL_LIFO, 4'd15);
    push_item(crp_pkg::KIND_QUERY, 8'd3, 3'd0, crp_pkg::OUT_HIT);

    // unused policy code with zero ways
    set_policy(POL_UNUSED, 4'd0);
    push_item(crp_pkg::KIND_ACCESS, 8'd2, 3'd0, crp_pkg::OUT_COMP_MISS);
    push_item(crp_pkg::KIND_QUERY, 8'd2, 3'd0, crp_pkg::OUT_HIT);

    set_policy(crp_pkg::POL_RANDOM, 4'd3);
    push_item(crp_pkg::KIND_QUERY, 8'd4, 3'd0, crp_pkg::OUT_HIT);
    push_item(crp_pkg::KIND_QUERY, 8'd4, 3'd0, crp_pkg::OUT_HIT);

    // random phases: sender gaps 34 percent, then 55, then none
    for (int p = 0; p < 15; p++) begin
      case (p)
        0: begin pol = crp_pkg::POL_LRU; ways = 4'd8; end
        1: begin pol = crp_pkg::POL_FIFO; ways = 4'd8; end
        2: begin pol = crp_pkg::POL_LFU; ways = 4'd1; end
        3: begin pol = crp_pkg::POL_RANDOM; ways = 4'd8; end
        4: begin pol = crp_pkg::POL_LIFO; ways = 4'd15; end
        5: begin pol = POL_MAX; ways = 4'd0; end
        default: begin
          pol = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(POL_MAX, POL_UNUSED)) :
                3'($urandom_range(crp_pkg::POL_LIFO, crp_pkg::POL_RANDOM));
          ways = ($urandom_range(9, 0) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
        end
      endcase
      set_policy(pol, ways);
      idle_pct = (p < 5) ? 34 : (p < 10) ? 55 : 0;
      random_phase(130);
    end

    settle();
    $display("ran %0d items, %0d victims checked, across %0d register settings",
             items_cnt, victims_cnt, settings_cnt);
    $display("policies random/lru/lfu/fifo/lifo/unused, clamped and zero way counts");
    if (err_cnt == 0) begin
      $display("cache_replacement_policy_unit_tb OK");
    end else begin
      $display("cache_replacement_policy_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
